>>> hw/rtl/spd_pkg.sv
// Shared types, codes and the CRC-16 byte update for the stuffed packet deframer.
// Used by spd_front, spd_queue, spd_back and the top level; depends on nothing.
`default_nettype none
package spd_pkg;

  localparam logic [1:0] KIND_INSTR  = 2'd0;
  localparam logic [1:0] KIND_PARAM  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_CRC_BAD  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  localparam logic [7:0]  BYTE_FF    = 8'hFF;
  localparam logic [7:0]  BYTE_FD    = 8'hFD;
  localparam logic [7:0]  BYTE_00    = 8'h00;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] CRC_MSB    = 16'h8000;
  localparam logic [23:0] HDR_PREFIX = 24'hFFFFFD;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_id;
    logic [15:0] param_index;
    logic [1:0]  status;
    logic        last;
  } spd_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    spd_item_t  item0;
    spd_item_t  item1;
  } spd_push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_HDR =
    crc_byte(crc_byte(crc_byte(crc_byte(16'h0000, BYTE_FF), BYTE_FF), BYTE_FD), BYTE_00);

endpackage
`default_nettype wire

>>> hw/rtl/stuffed_packet_deframer_core.sv
// Top level of the stuffed packet deframer: front parser, result queue and output register.
// Depends on spd_pkg, spd_front, spd_queue and spd_back.
//
// The input channel (in_valid, in_ready, in_rx_byte) takes one received byte per request.
// The block hunts for the header FF FF FD 00, reads the id and length, destuffs the body
// and sends out the instruction byte, the parameter bytes and one end-of-frame status on
// the result channel (out_valid, out_ready and the out_ payload ports).
// A byte's results are written to a four-entry queue at the accepting edge and move on to
// the output register when it is empty or its result is taken. One byte is taken every
// cycle while in_ready is high, and one result leaves every cycle while out_ready is high
// and the queue is not empty. A byte that breaks a held FD gives two results; the extra
// one drains through the queue, and in_ready drops while the queue holds more than two.
// When the receiver holds out_ready low, the output register keeps its request, the
// queue fills and in_ready falls; nothing is lost or repeated.
// Reset clears the parser to hunting, empties the queue and drops out_valid; in_ready is
// low while rst_n is low.
`default_nettype none
module stuffed_packet_deframer_core
  import spd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_frame_id,
  output logic [15:0]      out_param_index,
  output logic [1:0]       out_status,
  output logic             out_last
);

  spd_push_t push;
  logic      space_ok;
  logic      q_valid;
  spd_item_t q_item;
  logic      pop;

  spd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .space_ok   (space_ok),
    .push       (push)
  );

  spd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop)
  );

  spd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_frame_id    (out_frame_id),
    .out_param_index (out_param_index),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

>>> hw/rtl/spd_front.sv
// Front part: accepts received bytes, hunts for the header, destuffs the body and checks the CRC.
// Produces zero, one or two result items per byte for spd_queue; depends on spd_pkg.
`default_nettype none
module spd_front
  import spd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       space_ok,
  output spd_push_t       push
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_CRC_LO = 3'd5;
  localparam logic [2:0] PH_CRC_HI = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [23:0] window_r, window_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [1:0]  ff_run_r, ff_run_nxt;
  logic        held_r, held_nxt;
  logic [15:0] boc_r, boc_nxt;

  logic        fire;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic        is_last;
  logic [15:0] boc_inc1;
  logic [15:0] boc_inc2;
  logic [15:0] rx_crc;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic spd_item_t body_item(input logic [7:0] d, input logic [15:0] cnt,
                                          input logic [7:0] id);
    spd_item_t it;
    it = '0;
    it.data_byte = d;
    it.frame_id  = id;
    if (cnt == 16'd0) begin
      it.kind = KIND_INSTR;
    end else begin
      it.kind        = KIND_PARAM;
      it.param_index = cnt - 16'd1;
    end
    return it;
  endfunction

  function automatic spd_item_t status_item(input logic [1:0] st, input logic [7:0] id);
    spd_item_t it;
    it = '0;
    it.kind     = KIND_STATUS;
    it.frame_id = id;
    it.status   = st;
    it.last     = 1'b1;
    return it;
  endfunction

  assign in_ready = space_ok && rst_n;
  assign fire     = in_valid && in_ready;
  assign b        = in_rx_byte;
  assign crc_upd  = crc_byte(crc_r, b);
  assign len      = {b, len_lo_r};
  assign rem_dec  = (rem_r != 16'd0) ? rem_r - 16'd1 : 16'd0;
  assign is_last  = (rem_r <= 16'd1);
  assign boc_inc1 = sat_inc(boc_r);
  assign boc_inc2 = sat_inc(boc_inc1);
  assign rx_crc   = {b, crc_lo_r};

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    rem_nxt    = rem_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    ff_run_nxt = ff_run_r;
    held_nxt   = held_r;
    boc_nxt    = boc_r;
    push       = '0;
    if (fire) begin
      case (phase_r)
        PH_ID: begin
          id_nxt    = b;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_nxt = b;
          crc_nxt    = crc_upd;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          crc_nxt = crc_upd;
          if (len < 16'd2) begin
            push.cnt   = 2'd1;
            push.item0 = status_item(ST_SHORT, id_r);
            phase_nxt  = PH_HUNT;
            window_nxt = '0;
            ff_run_nxt = 2'd0;
            held_nxt   = 1'b0;
          end else begin
            rem_nxt   = len - 16'd2;
            phase_nxt = (len == 16'd2) ? PH_CRC_LO : PH_BODY;
          end
        end
        PH_BODY: begin
          crc_nxt = crc_upd;
          rem_nxt = rem_dec;
          if (held_r) begin
            held_nxt   = 1'b0;
            ff_run_nxt = 2'd0;
            push.item0 = body_item(BYTE_FD, boc_r, id_r);
            if (b != BYTE_FD) begin
              push.cnt   = 2'd2;
              push.item1 = body_item(b, boc_inc1, id_r);
              boc_nxt    = boc_inc2;
              ff_run_nxt = (b == BYTE_FF) ? 2'd1 : 2'd0;
            end else begin
              push.cnt = 2'd1;
              boc_nxt  = boc_inc1;
            end
          end else if (ff_run_r >= 2'd2 && b == BYTE_FD && !is_last) begin
            held_nxt   = 1'b1;
            ff_run_nxt = 2'd0;
          end else begin
            push.cnt   = 2'd1;
            push.item0 = body_item(b, boc_r, id_r);
            boc_nxt    = boc_inc1;
            if (b == BYTE_FF) begin
              ff_run_nxt = (ff_run_r >= 2'd2) ? 2'd2 : ff_run_r + 2'd1;
            end else begin
              ff_run_nxt = 2'd0;
            end
          end
          if (rem_dec == 16'd0) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = b;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          push.cnt = 2'd1;
          if (rx_crc != crc_r) begin
            push.item0 = status_item(ST_CRC_BAD, id_r);
          end else if (boc_r == 16'd0) begin
            push.item0 = status_item(ST_EMPTY, id_r);
          end else begin
            push.item0 = status_item(ST_GOOD, id_r);
          end
          phase_nxt  = PH_HUNT;
          window_nxt = '0;
          ff_run_nxt = 2'd0;
          held_nxt   = 1'b0;
        end
        default: begin
          if (window_r == HDR_PREFIX && b == BYTE_00) begin
            phase_nxt  = PH_ID;
            window_nxt = '0;
            crc_nxt    = CRC_HDR;
            ff_run_nxt = 2'd0;
            held_nxt   = 1'b0;
            boc_nxt    = 16'd0;
            rem_nxt    = 16'd0;
          end else begin
            phase_nxt  = PH_HUNT;
            window_nxt = {window_r[15:0], b};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= '0;
      id_r     <= '0;
      len_lo_r <= '0;
      rem_r    <= '0;
      crc_r    <= '0;
      crc_lo_r <= '0;
      ff_run_r <= '0;
      held_r   <= 1'b0;
      boc_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      id_r     <= id_nxt;
      len_lo_r <= len_lo_nxt;
      rem_r    <= rem_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      ff_run_r <= ff_run_nxt;
      held_r   <= held_nxt;
      boc_r    <= boc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/spd_queue.sv
// Result queue between front and back: takes up to two items per cycle, gives one.
// Depends on spd_pkg.
`default_nettype none
module spd_queue
  import spd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire spd_push_t push,
  output logic           space_ok,
  output logic           q_valid,
  output spd_item_t      q_item,
  input  wire logic      pop
);

  spd_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic [QPTR_W-1:0]  wr_ptr_p1;

  assign space_ok  = (count_r <= QCNT_W'(QDEPTH - 2));
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("Result queue count exceeds its depth.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !pop)
    else $error("Result queue popped while empty.");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > QCNT_W'(QDEPTH - 2)) |-> (push.cnt == 2'd0))
    else $error("Result queue written without room for two items.");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
    else $error("Result queue pointers disagree with its count.");

endmodule
`default_nettype wire

>>> hw/rtl/spd_back.sv
// Back part: output register that hands queued result items to the receiver.
// Depends on spd_pkg.
`default_nettype none
module spd_back
  import spd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire spd_item_t   q_item,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_frame_id,
  output logic [15:0]      out_param_index,
  output logic [1:0]       out_status,
  output logic             out_last
);

  logic      valid_r, valid_nxt;
  spd_item_t item_r;

  assign pop       = q_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = item_r.kind;
  assign out_data_byte   = item_r.data_byte;
  assign out_frame_id    = item_r.frame_id;
  assign out_param_index = item_r.param_index;
  assign out_status      = item_r.status;
  assign out_last        = item_r.last;

endmodule
`default_nettype wire
